[hdl/gpuf_pkg.sv]
package gpuf_pkg;

    localparam int GRID_SIDE_DEF = 32;
    localparam int SIDE_RESET    = 32;
    localparam int SIDE_W        = 6;
    localparam int ROW_W         = 6;
    localparam int COL_W         = 6;

    // Steps of one open request, in the order they are worked through.
    typedef enum logic [2:0] {
        JOB_UP     = 3'd0,
        JOB_DOWN   = 3'd1,
        JOB_LEFT   = 3'd2,
        JOB_RIGHT  = 3'd3,
        JOB_TOP    = 3'd4,
        JOB_BOTTOM = 3'd5,
        JOB_REPORT = 3'd6
    } t_job;

    typedef struct packed {
        logic clr;
        logic load;
        logic setup;
        logic open_site;
        logic open_wr;
        logic chk;
        logic start_a;
        logic latch_a;
        logic start_b;
        logic link;
        logic out_load;
        t_job job;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic err;
        logic mode;
        logic open_q;
        logic job_ok;
        logic busy;
        logic out_free;
    } t_stat;

endpackage

[hdl/gpuf_if.sv]
interface gpuf_cfg_if;
    import gpuf_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIDE_W-1:0] active_side;
    modport source (output valid, output active_side, input ready);
    modport sink (input valid, input active_side, output ready);
endinterface

interface gpuf_in_if;
    import gpuf_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    modport source (output valid, output mode, output row, output col, input ready);
    modport sink (input valid, input mode, input row, input col, output ready);
endinterface

interface gpuf_out_if;
    logic valid;
    logic ready;
    logic site_open;
    logic site_full;
    logic grid_percolates;
    logic coord_error;
    modport source (output valid, output site_open, output site_full,
                    output grid_percolates, output coord_error, input ready);
    modport sink (input valid, input site_open, input site_full,
                  input grid_percolates, input coord_error, output ready);
endinterface

[hdl/grid_percolation_union_find.sv]
// Channel   Dir  Payload                                         Request taken when
// i_cfg     in   active_side                                     valid && ready
// i_in      in   mode, row, col                                  valid && ready
// o_out     out  site_open, site_full, grid_percolates, coord_error  valid && ready
//
// A report-only request passes through the control states and two walk phases, each
// phase one step longer per parent hop in the deeper store.
// An open adds the neighbour steps, one read per neighbour inside the grid, and for
// each of up to four unions two more walk phases and a link step.
// After reset and each side write, a pass clears all GRID_SIDE^2+2 nodes first.
// A stalled result stays in the output register and the next result waits for it.
module grid_percolation_union_find #(
    parameter int GRID_SIDE = gpuf_pkg::GRID_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gpuf_cfg_if.sink          i_cfg,
    gpuf_in_if.sink           i_in,
    gpuf_out_if.source        o_out
);
    import gpuf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;
    logic  in_ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign i_in.ready  = in_ready;

    gpuf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gpuf_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr          (cfg_wr),
        .i_cfg_side        (i_cfg.active_side),
        .i_mode            (i_in.mode),
        .i_row             (i_in.row),
        .i_col             (i_in.col),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_site_open       (o_out.site_open),
        .o_site_full       (o_out.site_full),
        .o_grid_percolates (o_out.grid_percolates),
        .o_coord_error     (o_out.coord_error)
    );

endmodule

[hdl/gpuf_walk.sv]
module gpuf_walk #(
    parameter int  DEPTH = gpuf_pkg::GRID_SIDE_DEF * gpuf_pkg::GRID_SIDE_DEF + 2,
    localparam int NB    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NB-1:0] i_node,
    input  logic          i_we,
    input  logic [NB-1:0] i_waddr,
    input  logic [NB-1:0] i_wdata,
    output logic          o_busy,
    output logic [NB-1:0] o_root
);
    import gpuf_pkg::*;

    logic [NB-1:0] r_par [DEPTH];
    logic [NB-1:0] r_q;
    logic [NB-1:0] r_qa;
    logic          r_busy;
    logic          at_root;
    logic          rd_en;
    logic [NB-1:0] rd_addr;

    // One parent hop per cycle: the parent read last cycle is the next address.
    assign at_root = (r_q == r_qa);
    assign rd_en   = i_start || (r_busy && !at_root);
    assign rd_addr = i_start ? i_node : r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_par[i_waddr] <= i_wdata;
        end
        if (rd_en) begin
            r_q  <= r_par[rd_addr];
            r_qa <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && at_root) begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_qa;

endmodule

[hdl/gpuf_dp.sv]
module gpuf_dp #(
    parameter int GRID_SIDE = gpuf_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr,
    input  logic [gpuf_pkg::SIDE_W-1:0] i_cfg_side,
    input  logic                        i_mode,
    input  logic [gpuf_pkg::ROW_W-1:0]  i_row,
    input  logic [gpuf_pkg::COL_W-1:0]  i_col,
    input  gpuf_pkg::t_cmd              i_cmd,
    output gpuf_pkg::t_stat             o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_site_open,
    output logic                        o_site_full,
    output logic                        o_grid_percolates,
    output logic                        o_coord_error
);
    import gpuf_pkg::*;

    localparam int SITES = GRID_SIDE * GRID_SIDE;
    localparam int NB    = $clog2(SITES + 2);
    localparam int AW    = $clog2(SITES);
    localparam int NW    = $clog2(GRID_SIDE + 1);
    localparam int CW    = (NW > ROW_W) ? NW : ROW_W;
    localparam int PW    = NW + ROW_W;
    localparam logic [NW-1:0] SIDE_MAX  = NW'(GRID_SIDE);
    localparam logic [NW-1:0] SIDE_RST  = NW'((SIDE_RESET > GRID_SIDE) ? GRID_SIDE : SIDE_RESET);
    localparam logic [NB-1:0] NODE_LAST = NB'(SITES + 1);
    localparam logic [NB-1:0] NODE_SITES = NB'(SITES);

    logic [NW-1:0]    r_n;
    logic [NB-1:0]    r_bottom;
    logic [NB-1:0]    r_clr;
    logic             r_mode;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_err;
    logic [NB-1:0]    r_site;
    logic             r_site_open;
    logic [NB-1:0]    r_ra_w;
    logic [NB-1:0]    r_ra_t;
    logic             r_open_q;
    logic             r_open [SITES];
    logic             r_out_valid;
    logic             r_out_open;
    logic             r_out_full;
    logic             r_out_perc;
    logic             r_out_err;

    logic [NW-1:0]    cfg_n;
    logic [2*NW-1:0]  sq;
    logic [PW-1:0]    prod;
    logic [NB-1:0]    site_calc;
    logic             in_err;
    logic             job_ok;
    logic [NB-1:0]    a_node;
    logic [NB-1:0]    b_w;
    logic [NB-1:0]    b_t;
    logic [NB-1:0]    rd_node;
    logic             rd_ok;
    logic             walk_start;
    logic             we_w;
    logic             we_t;
    logic [NB-1:0]    waddr_w;
    logic [NB-1:0]    waddr_t;
    logic [NB-1:0]    wdata_w;
    logic [NB-1:0]    wdata_t;
    logic             busy_w;
    logic             busy_t;
    logic [NB-1:0]    root_w;
    logic [NB-1:0]    root_t;

    // Side in use: zero acts as one, anything above the built grid as its side.
    always_comb begin
        if (i_cfg_side == '0) begin
            cfg_n = NW'(1);
        end else if (CW'(i_cfg_side) > CW'(SIDE_MAX)) begin
            cfg_n = SIDE_MAX;
        end else begin
            cfg_n = NW'(i_cfg_side);
        end
    end

    assign sq        = r_n * r_n;
    assign prod      = r_n * ROW_W'(r_row - ROW_W'(1));
    assign site_calc = NB'(prod + PW'(r_col));
    assign in_err    = (i_row == '0) || (CW'(i_row) > CW'(r_n))
                    || (i_col == '0) || (CW'(i_col) > CW'(r_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= SIDE_RST;
            r_clr <= '0;
        end else if (i_cfg_wr) begin
            r_n   <= cfg_n;
            r_clr <= '0;
        end else if (i_cmd.clr && (r_clr != NODE_LAST)) begin
            r_clr <= r_clr + NB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bottom <= NB'(sq) + NB'(1);
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_row  <= i_row;
            r_col  <= i_col;
            r_err  <= in_err;
        end
        if (i_cmd.setup) begin
            r_site <= r_err ? '0 : site_calc;
        end
        if (i_cmd.chk) begin
            r_site_open <= !r_err && (r_open_q || !r_mode);
        end
        if (i_cmd.latch_a) begin
            r_ra_w <= root_w;
            r_ra_t <= root_t;
        end
    end

    always_comb begin
        case (i_cmd.job)
            JOB_UP:     job_ok = (r_row != ROW_W'(1));
            JOB_DOWN:   job_ok = (CW'(r_row) < CW'(r_n));
            JOB_LEFT:   job_ok = (r_col != COL_W'(1));
            JOB_RIGHT:  job_ok = (CW'(r_col) < CW'(r_n));
            JOB_TOP:    job_ok = (r_row == ROW_W'(1));
            JOB_BOTTOM: job_ok = (CW'(r_row) == CW'(r_n));
            default:    job_ok = 1'b1;
        endcase
    end

    // Node pairs per step; the report walks top/bottom and top/site.
    always_comb begin
        a_node = (i_cmd.job == JOB_REPORT) ? '0 : r_site;
        case (i_cmd.job)
            JOB_UP: begin
                b_w = r_site - NB'(r_n);
                b_t = b_w;
            end
            JOB_DOWN: begin
                b_w = r_site + NB'(r_n);
                b_t = b_w;
            end
            JOB_LEFT: begin
                b_w = r_site - NB'(1);
                b_t = b_w;
            end
            JOB_RIGHT: begin
                b_w = r_site + NB'(1);
                b_t = b_w;
            end
            JOB_TOP: begin
                b_w = '0;
                b_t = '0;
            end
            default: begin
                b_w = r_bottom;
                b_t = r_site;
            end
        endcase
    end

    assign rd_node = i_cmd.open_site ? r_site : b_w;
    assign rd_ok   = (rd_node != '0) && (rd_node <= NODE_SITES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && (r_clr < NODE_SITES)) begin
            r_open[AW'(r_clr)] <= 1'b0;
        end else if (i_cmd.open_wr) begin
            r_open[AW'(r_site - NB'(1))] <= 1'b1;
        end
        if (rd_ok) begin
            r_open_q <= r_open[AW'(rd_node - NB'(1))];
        end else begin
            r_open_q <= 1'b0;
        end
    end

    assign walk_start = i_cmd.start_a || i_cmd.start_b;
    assign we_w    = i_cmd.clr || (i_cmd.link && (r_ra_w != root_w));
    assign waddr_w = i_cmd.clr ? r_clr : r_ra_w;
    assign wdata_w = i_cmd.clr ? r_clr : root_w;
    assign we_t    = (i_cmd.clr && (r_clr != NODE_LAST))
                  || (i_cmd.link && (i_cmd.job != JOB_BOTTOM) && (r_ra_t != root_t));
    assign waddr_t = i_cmd.clr ? r_clr : r_ra_t;
    assign wdata_t = i_cmd.clr ? r_clr : root_t;

    gpuf_walk #(.DEPTH(SITES + 2)) u_walk_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_node  (i_cmd.start_b ? b_w : a_node),
        .i_we    (we_w),
        .i_waddr (waddr_w),
        .i_wdata (wdata_w),
        .o_busy  (busy_w),
        .o_root  (root_w)
    );

    gpuf_walk #(.DEPTH(SITES + 1)) u_walk_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_node  (i_cmd.start_b ? b_t : a_node),
        .i_we    (we_t),
        .i_waddr (waddr_t),
        .i_wdata (wdata_t),
        .o_busy  (busy_t),
        .o_root  (root_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_open <= r_site_open;
            r_out_full <= r_site_open && (r_ra_t == root_t);
            r_out_perc <= (r_ra_w == root_w);
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_site_open       = r_out_open;
    assign o_site_full       = r_out_full;
    assign o_grid_percolates = r_out_perc;
    assign o_coord_error     = r_out_err;

    assign o_stat.clr_last = (r_clr == NODE_LAST);
    assign o_stat.err      = r_err;
    assign o_stat.mode     = r_mode;
    assign o_stat.open_q   = r_open_q;
    assign o_stat.job_ok   = job_ok;
    assign o_stat.busy     = busy_w || busy_t;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

[hdl/gpuf_ctrl.sv]
module gpuf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gpuf_pkg::t_stat i_stat,
    output gpuf_pkg::t_cmd  o_cmd
);
    import gpuf_pkg::*;

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_SETUP = 13'b0000000000100,
        ST_CHK   = 13'b0000000001000,
        ST_CHKW  = 13'b0000000010000,
        ST_JOB   = 13'b0000000100000,
        ST_NBRW  = 13'b0000001000000,
        ST_FA    = 13'b0000010000000,
        ST_FAW   = 13'b0000100000000,
        ST_FB    = 13'b0001000000000,
        ST_FBW   = 13'b0010000000000,
        ST_LINK  = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_job   r_job;
    t_job   n_job;
    t_job   job_next;

    assign job_next = t_job'(r_job + 3'd1);

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        o_cmd      = '0;
        o_cmd.job  = r_job;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.open_site = 1'b1;
                n_state         = ST_CHKW;
            end
            ST_CHKW: begin
                o_cmd.chk = 1'b1;
                if (i_stat.err || i_stat.mode || i_stat.open_q) begin
                    n_job   = JOB_REPORT;
                    n_state = ST_FA;
                end else begin
                    o_cmd.open_wr = 1'b1;
                    n_job         = JOB_UP;
                    n_state       = ST_JOB;
                end
            end
            ST_JOB: begin
                if (r_job == JOB_REPORT) begin
                    n_state = ST_FA;
                end else if (!i_stat.job_ok) begin
                    n_job = job_next;
                end else if (r_job == JOB_TOP || r_job == JOB_BOTTOM) begin
                    n_state = ST_FA;
                end else begin
                    // The neighbour's open bit is read this cycle.
                    n_state = ST_NBRW;
                end
            end
            ST_NBRW: begin
                if (i_stat.open_q) begin
                    n_state = ST_FA;
                end else begin
                    n_job   = job_next;
                    n_state = ST_JOB;
                end
            end
            ST_FA: begin
                o_cmd.start_a = 1'b1;
                n_state       = ST_FAW;
            end
            ST_FAW: begin
                if (!i_stat.busy) begin
                    o_cmd.latch_a = 1'b1;
                    n_state       = ST_FB;
                end
            end
            ST_FB: begin
                o_cmd.start_b = 1'b1;
                n_state       = ST_FBW;
            end
            ST_FBW: begin
                if (!i_stat.busy) begin
                    n_state = (r_job == JOB_REPORT) ? ST_OUT : ST_LINK;
                end
            end
            ST_LINK: begin
                o_cmd.link = 1'b1;
                n_job      = job_next;
                n_state    = ST_JOB;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        if (i_cfg_wr) begin
            n_state = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_job   <= JOB_REPORT;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gpuf_pkg::*;

    localparam int SIDE_MAX   = GRID_SIDE_DEF;
    localparam int SITES      = SIDE_MAX * SIDE_MAX;
    localparam int NODES_BOT  = SITES + 2;
    localparam int NODES_TOP  = SITES + 1;
    localparam int STALL_LIMIT = 200000;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic site_open;
        logic site_full;
        logic grid_percolates;
        logic coord_error;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    gpuf_cfg_if cfg_if();
    gpuf_in_if  in_if();
    gpuf_out_if out_if();

    grid_percolation_union_find i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Local copy of the grid state.
    logic [SIDE_W-1:0] side_reg;
    bit                site_is_open [SITES];
    int                par_bot [NODES_BOT];
    int                par_top [NODES_TOP];

    t_report report_queue[$];
    int      mismatches;
    bit      calm;
    int      idle_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    function automatic int side_now();
        if (side_reg < 1) return 1;
        if (side_reg > SIDE_MAX) return SIDE_MAX;
        return int'(side_reg);
    endfunction

    function automatic void wipe_grid();
        for (int k = 0; k < SITES; k++) site_is_open[k] = 1'b0;
        for (int k = 0; k < NODES_BOT; k++) par_bot[k] = k;
        for (int k = 0; k < NODES_TOP; k++) par_top[k] = k;
    endfunction

    function automatic int root_of(bit top_store, int x);
        int count;
        int steps;
        int p;
        count = top_store ? NODES_TOP : NODES_BOT;
        steps = 0;
        if (x >= count) return 0;
        forever begin
            p = top_store ? par_top[x] : par_bot[x];
            if (p == x || steps >= count || p >= count) break;
            x = p;
            steps++;
        end
        return x;
    endfunction

    function automatic void merge(bit top_store, int a, int b);
        int ra;
        int rb;
        ra = root_of(top_store, a);
        rb = root_of(top_store, b);
        if (ra != rb) begin
            if (top_store) par_top[ra] = rb;
            else par_bot[ra] = rb;
        end
    endfunction

    function automatic bit open_at(int n, int r, int c);
        int idx;
        idx = n * (r - 1) + (c - 1);
        return idx >= 0 && idx < SITES && site_is_open[idx];
    endfunction

    function automatic void merge_neighbor(int n, int site, int r, int c);
        int other;
        other = n * (r - 1) + c;
        if (!open_at(n, r, c)) return;
        if (root_of(1'b1, site) == root_of(1'b1, other)) return;
        merge(1'b0, site, other);
        merge(1'b1, site, other);
    endfunction

    function automatic t_report percolation_step(logic mode, int r, int c);
        t_report rep;
        int n;
        int site;
        int bottom;
        n = side_now();
        bottom = n * n + 1;
        rep = '0;
        if (r < 1 || r > n || c < 1 || c > n) begin
            rep.grid_percolates = root_of(1'b0, 0) == root_of(1'b0, bottom);
            rep.coord_error = 1'b1;
            return rep;
        end
        site = n * (r - 1) + c;
        if (mode == 1'b0 && !open_at(n, r, c)) begin
            site_is_open[site - 1] = 1'b1;
            if (r > 1) merge_neighbor(n, site, r - 1, c);
            if (r < n) merge_neighbor(n, site, r + 1, c);
            if (c > 1) merge_neighbor(n, site, r, c - 1);
            if (c < n) merge_neighbor(n, site, r, c + 1);
            if (r == 1) begin
                merge(1'b0, site, 0);
                merge(1'b1, site, 0);
            end
            if (r == n) merge(1'b0, site, bottom);
        end
        rep.grid_percolates = root_of(1'b0, 0) == root_of(1'b0, bottom);
        rep.site_open = open_at(n, r, c);
        rep.site_full = root_of(1'b1, 0) == root_of(1'b1, site);
        return rep;
    endfunction

    function automatic bit roll_idle();
        return !calm && $urandom_range(0, 99) < 35;
    endfunction

    // Result receiver: random back-pressure, unless in a calm stretch.
    always @(posedge i_clk) begin
        out_if.ready <= !roll_idle();
    end

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.site_open       = out_if.site_open;
            got.site_full       = out_if.site_full;
            got.grid_percolates = out_if.grid_percolates;
            got.coord_error     = out_if.coord_error;
            if (report_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %b with nothing pending", got);
            end else begin
                want = report_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: open/full/perc/err expected %b got %b",
                                 want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no request moving on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_site(logic mode, logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        if (roll_idle()) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while (roll_idle());
        end
        in_if.valid <= 1'b1;
        in_if.mode  <= mode;
        in_if.row   <= r;
        in_if.col   <= c;
        do @(posedge i_clk); while (!in_if.ready);
        report_queue.push_back(percolation_step(mode, int'(r), int'(c)));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (report_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(logic [SIDE_W-1:0] v);
        wait_drained();
        cfg_if.valid       <= 1'b1;
        cfg_if.active_side <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        side_reg = v;
        wipe_grid();
    endtask

    task automatic test_reset_grid();
        send_site(1'b1, 1, 1);
        send_site(1'b0, 0, 5);
        send_site(1'b0, 5, 0);
        send_site(1'b0, 33, 1);
        send_site(1'b0, 1, 63);
        send_site(1'b0, 1, 1);
        send_site(1'b0, 1, 1);
        send_site(1'b0, 32, 32);
        send_site(1'b0, 1, 32);
        send_site(1'b1, 32, 32);
        send_site(1'b0, 2, 1);
        send_site(1'b1, 2, 1);
    endtask

    task automatic test_side_limits();
        write_side(1);
        send_site(1'b1, 1, 1);
        send_site(1'b0, 1, 2);
        send_site(1'b0, 1, 1);
        write_side(0);
        send_site(1'b0, 1, 1);
        send_site(1'b0, 2, 2);
        write_side(63);
        send_site(1'b0, 32, 1);
        send_site(1'b1, 33, 33);
    endtask

    // A full column percolates; a bottom site touching only the bottom node
    // must not look full through the bottom node.
    task automatic test_backwash();
        write_side(3);
        for (int r = 1; r <= 3; r++) send_site(1'b0, ROW_W'(r), 1);
        send_site(1'b0, 3, 3);
        send_site(1'b1, 3, 3);
        send_site(1'b1, 2, 1);
    endtask

    task automatic test_random_phases();
        logic [SIDE_W-1:0] sides [10];
        int n;
        sides = '{2, 3, 4, 5, 6, 8, 1, 32, 4, 7};
        for (int ph = 0; ph < 10; ph++) begin
            write_side(ph == 9 ? SIDE_W'($urandom_range(0, 63)) : sides[ph]);
            n = side_now();
            calm = (ph == 3);
            for (int k = 0; k < 45; k++) begin
                if (ph == 5 && k == 20) wait_drained();
                if ($urandom_range(0, 99) < 85)
                    send_site($urandom_range(0, 99) < 25, ROW_W'($urandom_range(1, n)),
                              COL_W'($urandom_range(1, n)));
                else
                    send_site(1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 63)),
                              COL_W'($urandom_range(0, 63)));
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        mismatches = 0;
        calm = 1'b0;
        side_reg = SIDE_RESET;
        wipe_grid();
        i_rst_n            <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.active_side <= '0;
        in_if.valid        <= 1'b0;
        in_if.mode         <= 1'b0;
        in_if.row          <= '0;
        in_if.col          <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_grid();
        test_side_limits();
        test_backwash();
        test_random_phases();
        wait_drained();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
